[rtl/core/fat_pkg.sv]
// ----------------------------------------------------------------------------
// fat_pkg
// Types and constants shared by the flow accounting table.
// ----------------------------------------------------------------------------
package fat_pkg;

    localparam int TableEntriesDefault = 256;
    localparam int KeyWidth            = 104;
    localparam int CountWidth          = 32;
    localparam int TimeWidth           = 48;
    localparam int ActiveWidth         = 9;

    localparam logic [1:0] StatusHit    = 2'd0;
    localparam logic [1:0] StatusInsert = 2'd1;
    localparam logic [1:0] StatusFull   = 2'd2;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
        logic [15:0] packet_length;
        logic [47:0] timestamp;
    } pkt_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] flow_packets;
        logic [31:0] flow_bytes;
        logic [47:0] first_seen_time;
        logic [8:0]  active_flows;
    } pkt_out_t;

    // Per-entry accounting record.
    typedef struct packed {
        logic [CountWidth-1:0] packets;
        logic [CountWidth-1:0] bytes;
        logic [TimeWidth-1:0]  first_time;
        logic [TimeWidth-1:0]  last_time;
    } acct_t;

    localparam int AcctWidth = $bits(acct_t);

    function automatic logic [KeyWidth-1:0] key_of(input pkt_in_t p);
        return {p.src_ip, p.dst_ip, p.sport, p.dport, p.protocol};
    endfunction

endpackage

[rtl/core/fat_ram.sv]
// ----------------------------------------------------------------------------
// fat_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module fat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/core/fat_queue.sv]
// ----------------------------------------------------------------------------
// fat_queue
// Front part: accept transactions into a short queue for the back part.
// ----------------------------------------------------------------------------
module fat_queue
    import fat_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  pkt_in_t in_item,
    output logic    busy,
    output logic    q_valid,
    output pkt_in_t q_item,
    input  logic    q_pop
);

    localparam int Depth = 2;

    pkt_in_t           slot_reg [Depth];
    logic              rd_ptr_reg;
    logic              wr_ptr_reg;
    logic [1:0]        count_reg;
    logic              push;

    assign busy    = (count_reg == 2'(Depth));
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

[rtl/core/fat_engine.sv]
// ----------------------------------------------------------------------------
// fat_engine
// Back part: scan stored keys one a cycle, then update or insert the flow, or report the table full.
// ----------------------------------------------------------------------------
module fat_engine
    import fat_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDefault
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  pkt_in_t  q_item,
    output logic     q_pop,
    output logic     done,
    output pkt_out_t result
);

    localparam int AddrWidth = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CntWidth  = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [2:0] {
        IDLE,
        SCAN,
        CHECK,
        READ,
        WRITE
    } state_t;

    state_t                state_reg;
    logic [CntWidth-1:0]   flow_count_reg;
    logic [CntWidth-1:0]   idx_reg;
    logic [AddrWidth-1:0]  hit_idx_reg;
    logic                  done_reg;
    pkt_out_t              result_reg;

    logic                  key_we;
    logic                  acct_we;
    logic [AddrWidth-1:0]  addr;
    logic [KeyWidth-1:0]   key_rdata;
    acct_t                 acct_rdata;
    acct_t                 acct_wdata;
    logic [KeyWidth-1:0]   key;
    logic                  is_hit;

    assign key = key_of(q_item);
    assign is_hit = (state_reg == WRITE);

    always_comb
    begin
        addr = idx_reg[AddrWidth-1:0];
        if (state_reg == READ || state_reg == WRITE)
        begin
            addr = hit_idx_reg;
        end
        else if (state_reg == CHECK)
        begin
            addr = flow_count_reg[AddrWidth-1:0];
        end
    end

    assign key_we  = (state_reg == CHECK) && (flow_count_reg != CntWidth'(TABLE_ENTRIES));
    assign acct_we = key_we || is_hit;

    always_comb
    begin
        if (is_hit)
        begin
            acct_wdata.packets    = acct_rdata.packets + 32'd1;
            acct_wdata.bytes      = acct_rdata.bytes + 32'(q_item.packet_length);
            acct_wdata.first_time = acct_rdata.first_time;
            acct_wdata.last_time  = q_item.timestamp;
        end
        else
        begin
            acct_wdata.packets    = 32'd1;
            acct_wdata.bytes      = 32'(q_item.packet_length);
            acct_wdata.first_time = q_item.timestamp;
            acct_wdata.last_time  = q_item.timestamp;
        end
    end

    fat_ram #(.WIDTH(KeyWidth), .DEPTH(TABLE_ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .addr  (addr),
        .wdata (key),
        .rdata (key_rdata)
    );

    fat_ram #(.WIDTH(AcctWidth), .DEPTH(TABLE_ENTRIES)) u_acct_ram (
        .clk   (clk),
        .we    (acct_we),
        .addr  (addr),
        .wdata (acct_wdata),
        .rdata (acct_rdata)
    );

    assign q_pop  = (state_reg == CHECK) || is_hit;
    assign done   = done_reg;
    assign result = result_reg;

    // SCAN: address idx_reg issued; its key is read back in the next cycle, when rd_idx_reg holds that index.
    logic                 rd_valid_reg;
    logic [AddrWidth-1:0] rd_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            flow_count_reg <= '0;
            idx_reg        <= '0;
            hit_idx_reg    <= '0;
            rd_valid_reg   <= 1'b0;
            rd_idx_reg     <= '0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (q_valid)
                    begin
                        idx_reg      <= '0;
                        rd_valid_reg <= 1'b0;
                        state_reg    <= SCAN;
                    end
                end
                SCAN:
                begin
                    if (rd_valid_reg && key_rdata == key)
                    begin
                        hit_idx_reg <= rd_idx_reg;
                        state_reg   <= READ;
                    end
                    else if (idx_reg >= flow_count_reg)
                    begin
                        if (!rd_valid_reg || rd_idx_reg == AddrWidth'(idx_reg - 1'b1)
                            || flow_count_reg == '0)
                        begin
                            state_reg <= CHECK;
                        end
                        rd_valid_reg <= 1'b0;
                    end
                    else
                    begin
                        rd_valid_reg <= 1'b1;
                        rd_idx_reg   <= idx_reg[AddrWidth-1:0];
                        idx_reg      <= idx_reg + 1'b1;
                    end
                end
                CHECK:
                begin
                    done_reg <= 1'b1;
                    if (flow_count_reg != CntWidth'(TABLE_ENTRIES))
                    begin
                        flow_count_reg             <= flow_count_reg + 1'b1;
                        result_reg.status          <= StatusInsert;
                        result_reg.flow_packets    <= 32'd1;
                        result_reg.flow_bytes      <= 32'(q_item.packet_length);
                        result_reg.first_seen_time <= q_item.timestamp;
                        result_reg.active_flows    <= 9'(flow_count_reg + 1'b1);
                    end
                    else
                    begin
                        result_reg.status          <= StatusFull;
                        result_reg.flow_packets    <= '0;
                        result_reg.flow_bytes      <= '0;
                        result_reg.first_seen_time <= '0;
                        result_reg.active_flows    <= 9'(flow_count_reg);
                    end
                    state_reg <= IDLE;
                end
                READ:
                begin
                    state_reg <= WRITE;
                end
                WRITE:
                begin
                    done_reg                   <= 1'b1;
                    result_reg.status          <= StatusHit;
                    result_reg.flow_packets    <= acct_wdata.packets;
                    result_reg.flow_bytes      <= acct_wdata.bytes;
                    result_reg.first_seen_time <= acct_wdata.first_time;
                    result_reg.active_flows    <= 9'(flow_count_reg);
                    state_reg                  <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/flow_accounting_table.sv]
// ----------------------------------------------------------------------------
// flow_accounting_table
// Exact-match flow cache with per-flow packet, byte and time accounting.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; a two-entry
// queue holds up to two pending packets. Each packet's key is compared
// against the stored flows one per cycle through the key RAM port. A miss
// ends in CHECK, which inserts the flow or drops the packet if the table is
// full; a hit goes through READ and WRITE to update the entry. The result
// is shown for one cycle with done high and cannot be stalled.
module flow_accounting_table
    import fat_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDefault
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  pkt_in_t  in_item,
    output logic     busy,
    output logic     done,
    output pkt_out_t result
);

    logic    q_valid;
    logic    q_pop;
    pkt_in_t q_item;

    fat_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_item (in_item),
        .busy    (busy),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    fat_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .done    (done),
        .result  (result)
    );

endmodule

[rtl/core/fat_checker.sv]
// ----------------------------------------------------------------------------
// fat_checker
// Port-level checks on the flow accounting table.
// ----------------------------------------------------------------------------
module fat_checker
    import fat_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input pkt_out_t result
);

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == StatusHit || result.status == StatusInsert
                  || result.status == StatusFull))
        else $error("bad status");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == StatusFull) |-> (result.flow_packets == '0))
        else $error("dropped packet reports counts");

    a_insert_one: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == StatusInsert) |-> (result.flow_packets == 32'd1))
        else $error("insert count not one");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back to back results");

    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a transaction");

endmodule

bind flow_accounting_table fat_checker u_fat_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
